>>> rtl/core/sfir_pkg.sv
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared types, widths and the folded Q15 coefficient table for the 23-tap
// symmetric FIR.
// ----------------------------------------------------------------------------
`default_nettype none

package sfir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PAIR_W     = 17;
  localparam int COEF_W     = 15;
  localparam int ACC_W      = 32;
  localparam int FRAC_BITS  = 15;
  localparam int NUM_STEPS  = 12;
  localparam int SPAN_DELAY = 22;
  localparam int AGE_W      = 5;
  localparam int STEP_W     = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One multiply-accumulate step travelling down the datapath
  typedef struct packed {
    logic              vld;
    logic [STEP_W-1:0] idx;
    logic              last;
  } step_t;

  // Folded coefficients; the last entry is the centre tap
  function automatic logic [COEF_W-1:0] coef(input logic [STEP_W-1:0] idx);
    logic [COEF_W-1:0] c;
    unique case (idx)
      4'd0:    c = 15'd688;
      4'd1:    c = 15'd1283;
      4'd2:    c = 15'd2316;
      4'd3:    c = 15'd3709;
      4'd4:    c = 15'd5439;
      4'd5:    c = 15'd7431;
      4'd6:    c = 15'd9561;
      4'd7:    c = 15'd11666;
      4'd8:    c = 15'd13563;
      4'd9:    c = 15'd15074;
      4'd10:   c = 15'd16047;
      4'd11:   c = 15'd16384;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sfir_ring.sv
// ----------------------------------------------------------------------------
// sfir_ring
// Sample delay line: one write port, two registered read ports, with a valid
// bit per entry so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_ring #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  sfir_pkg::sample_t   wr_data,
  input  logic [AW-1:0]       rd0_addr,
  input  logic [AW-1:0]       rd1_addr,
  input  logic                rd1_en,
  output sfir_pkg::sample_t   rd0_data,
  output sfir_pkg::sample_t   rd1_data
);

  sfir_pkg::sample_t mem [DEPTH];
  logic [DEPTH-1:0]  written;
  sfir_pkg::sample_t rd0_q;
  sfir_pkg::sample_t rd1_q;
  logic              rd0_ok;
  logic              rd1_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0_q <= mem[rd0_addr];
    rd1_q <= mem[rd1_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd0_ok  <= 1'b0;
      rd1_ok  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      rd0_ok <= written[rd0_addr];
      rd1_ok <= rd1_en & written[rd1_addr];
    end
  end

  // Unwritten entries, and a disabled second port, read as zero
  assign rd0_data = rd0_ok ? rd0_q : '0;
  assign rd1_data = rd1_ok ? rd1_q : '0;

endmodule

`default_nettype wire

>>> rtl/core/sfir_mac.sv
// ----------------------------------------------------------------------------
// sfir_mac
// Shared folded multiply-accumulate: pair add, coefficient multiply and
// 32-bit wrapping accumulate, one register stage each.
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  sfir_pkg::step_t                     step,
  input  sfir_pkg::sample_t                   tap0,
  input  sfir_pkg::sample_t                   tap1,
  output logic                                done,
  output logic [sfir_pkg::ACC_W-1:0]          acc
);

  localparam int PROD_W = sfir_pkg::COEF_W + 1 + sfir_pkg::PAIR_W;

  sfir_pkg::step_t                      s2;
  sfir_pkg::step_t                      s3;
  sfir_pkg::step_t                      s4;
  logic signed [sfir_pkg::PAIR_W-1:0]   pair_q;
  logic [sfir_pkg::ACC_W-1:0]           prod_q;
  logic signed [sfir_pkg::COEF_W:0]     coef_s;
  logic signed [PROD_W-1:0]             prod_full;

  // s2 rides with the read taps, s3 with the pair sum, s4 with the product
  assign coef_s    = $signed({1'b0, sfir_pkg::coef(s3.idx)});
  assign prod_full = coef_s * pair_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
    end else begin
      s2 <= step;
      s3 <= s2;
      s4 <= s3;
    end
  end

  always_ff @(posedge clk) begin
    pair_q <= $signed({tap0[sfir_pkg::SAMPLE_W-1], tap0})
            + $signed({tap1[sfir_pkg::SAMPLE_W-1], tap1});
    prod_q <= prod_full[sfir_pkg::ACC_W-1:0];
  end

  // Accumulator wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (s4.vld) begin
      acc <= acc + prod_q;
    end
  end

  assign done = s4.vld & s4.last;

endmodule

`default_nettype wire

>>> rtl/core/symmetric_fir_23_tap.sv
// ----------------------------------------------------------------------------
// symmetric_fir_23_tap
// 23-tap linear-phase FIR for one photodiode channel: folded pairs, one
// shared multiply-accumulate under a small sequencer.
// ----------------------------------------------------------------------------
// Each accepted sample is written into a RING_DEPTH-entry delay line and one
// filtered sample is returned: the 11 folded tap pairs and the centre tap,
// last, are run through a single multiplier and accumulator, one step per
// cycle, and the 32-bit sum is shifted right by 15 and wrapped to 16 bits.
// An item is issued step by step into the shared multiply-accumulate,
// passes its 3 register stages and then the output register; the input
// stays stalled while a sample is being worked on, so the next sample is
// taken only once the last result has entered the output register.
// A finished result waits in the output register while the next sample
// is accepted. The delay line reads as zero until written, with no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetric_fir_23_tap #(
  parameter int RING_DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [15:0]       sample_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       filtered_out
);

  localparam int AW = $clog2(RING_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                        state;
  logic [sfir_pkg::STEP_W-1:0]       cnt;
  logic [AW-1:0]                     wp;
  logic [AW-1:0]                     base;
  logic                              in_acc;
  logic                              issuing;
  sfir_pkg::step_t                   step;
  logic [sfir_pkg::AGE_W-1:0]        age0;
  logic [sfir_pkg::AGE_W-1:0]        age1;
  logic [AW-1:0]                     rd0_addr;
  logic [AW-1:0]                     rd1_addr;
  sfir_pkg::sample_t                 tap0;
  sfir_pkg::sample_t                 tap1;
  logic                              mac_done;
  logic [sfir_pkg::ACC_W-1:0]        acc;
  logic                              out_free;

  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] b,
                                              input logic [sfir_pkg::AGE_W-1:0] a);
    logic [AW:0] t;
    t = {1'b0, b} + (AW+1)'(RING_DEPTH) - (AW+1)'(a);
    if (t >= (AW+1)'(RING_DEPTH)) begin
      t = t - (AW+1)'(RING_DEPTH);
    end
    return t[AW-1:0];
  endfunction

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  assign issuing   = (state == S_RUN) && (cnt < sfir_pkg::STEP_W'(sfir_pkg::NUM_STEPS));
  assign step.vld  = issuing;
  assign step.idx  = cnt;
  assign step.last = (cnt == sfir_pkg::STEP_W'(sfir_pkg::NUM_STEPS - 1));

  // Pair k reads ages k and 22-k; the centre step reads age 11 alone
  assign age0     = sfir_pkg::AGE_W'(cnt);
  assign age1     = sfir_pkg::AGE_W'(sfir_pkg::SPAN_DELAY) - sfir_pkg::AGE_W'(cnt);
  assign rd0_addr = ring_addr(base, age0);
  assign rd1_addr = ring_addr(base, age1);

  sfir_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_acc),
    .wr_addr  (wp),
    .wr_data  (sample_in),
    .rd0_addr (rd0_addr),
    .rd1_addr (rd1_addr),
    .rd1_en   (issuing && !step.last),
    .rd0_data (tap0),
    .rd1_data (tap1)
  );

  sfir_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .clear (in_acc),
    .step  (step),
    .tap0  (tap0),
    .tap1  (tap1),
    .done  (mac_done),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      wp        <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_RUN;
            cnt   <= '0;
            wp    <= (wp == AW'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
          end
        end
        S_RUN: begin
          if (issuing) begin
            cnt <= cnt + 1'b1;
          end
          if (mac_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the sum until the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      base <= wp;
    end
    if (state == S_DONE && out_free) begin
      filtered_out <= $signed(acc[sfir_pkg::FRAC_BITS + 15:sfir_pkg::FRAC_BITS]);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= sfir_pkg::STEP_W'(sfir_pkg::NUM_STEPS))
    else $error("step counter past last pair");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == S_RUN) && (cnt == sfir_pkg::STEP_W'(sfir_pkg::NUM_STEPS)))
    else $error("accumulate finished outside its run");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised without a finished sum");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_RUN) && (cnt == '0))
    else $error("accepted transaction did not start a run");

endmodule

`default_nettype wire
